// File: sv/qkc_pkg.sv
// Shared types and constants for the quadkey codec.
// No dependencies; used by qkc_encoder, qkc_decoder and quadkey_codec.
`default_nettype none

package qkc_pkg;

	// Field widths fixed by the tile coordinate format
	localparam int unsigned TILE_BITS = 29;
	localparam int unsigned ZOOM_W    = 5;
	localparam int unsigned CHAR_W    = 8;

	// ASCII key digits
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_THREE = 8'h33;
	localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;

	// Function select carried on tuser of the input beat
	localparam logic FUNC_ENCODE = 1'b0;
	localparam logic FUNC_DECODE = 1'b1;

	// One result beat
	typedef struct packed {
		logic [CHAR_W-1:0]    digit;
		logic [TILE_BITS-1:0] x;
		logic [TILE_BITS-1:0] y;
		logic [ZOOM_W-1:0]    zoom;
		logic                 ok;
		logic                 last;
	} qkc_result_t;

endpackage

`default_nettype wire

// File: sv/qkc_encoder.sv
// Bit-serial quadkey encoder: column and row shift registers, one digit per cycle
// while advance is high. Depends on qkc_pkg.
`default_nettype none

module qkc_encoder #(
	parameter int unsigned ZOOM_LIMIT = 29
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 start,
	input  wire                                 advance,
	input  wire  [qkc_pkg::TILE_BITS-1:0]       tile_x,
	input  wire  [qkc_pkg::TILE_BITS-1:0]       tile_y,
	input  wire  [qkc_pkg::ZOOM_W-1:0]          zoom,
	output logic                                busy,
	output logic                                res_valid,
	output qkc_pkg::qkc_result_t                res
);

	localparam logic [qkc_pkg::ZOOM_W-1:0] LIMIT = qkc_pkg::ZOOM_W'(ZOOM_LIMIT);
	localparam int unsigned MSB = qkc_pkg::TILE_BITS - 1;

	logic [qkc_pkg::ZOOM_W-1:0]    z_clamp;
	logic [qkc_pkg::ZOOM_W-1:0]    shift_amt;
	logic [qkc_pkg::ZOOM_W-1:0]    cnt_q;
	logic [qkc_pkg::TILE_BITS-1:0] col_q;
	logic [qkc_pkg::TILE_BITS-1:0] row_q;

	// saturate zoom, then align the top digit to the MSB
	assign z_clamp   = (zoom > LIMIT) ? LIMIT : zoom;
	assign shift_amt = qkc_pkg::ZOOM_W'(qkc_pkg::TILE_BITS) - z_clamp;
	assign busy      = (cnt_q != '0);

	// digits left to emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start && z_clamp != '0) begin
			cnt_q <= z_clamp;
		end else if (busy && advance) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// coordinate shift registers, MSB first
	always_ff @(posedge clk) begin
		if (start) begin
			col_q <= tile_x << shift_amt;
			row_q <= tile_y << shift_amt;
		end else if (busy && advance) begin
			col_q <= {col_q[MSB-1:0], 1'b0};
			row_q <= {row_q[MSB-1:0], 1'b0};
		end
	end

	// result beat: a digit while busy, the empty marked result for zoom 0
	always_comb begin
		res      = '0;
		res.ok   = 1'b1;
		res.last = 1'b1;
		if (busy) begin
			res.digit = qkc_pkg::CHAR_ZERO
				+ {{(qkc_pkg::CHAR_W-2){1'b0}}, row_q[MSB], col_q[MSB]};
			res.last  = (cnt_q == qkc_pkg::ZOOM_W'(1));
		end
	end

	assign res_valid = busy | (start && z_clamp == '0);

endmodule

`default_nettype wire

// File: sv/qkc_decoder.sv
// Quadkey decoder: shifts two bits per key character into column and row.
// Depends on qkc_pkg.
`default_nettype none

module qkc_decoder #(
	parameter int unsigned ZOOM_LIMIT = 29
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 char_valid,
	input  wire  [qkc_pkg::CHAR_W-1:0]          key_char,
	input  wire                                 last_char,
	output logic                                res_valid,
	output qkc_pkg::qkc_result_t                res
);

	localparam logic [qkc_pkg::ZOOM_W-1:0] LIMIT = qkc_pkg::ZOOM_W'(ZOOM_LIMIT);
	localparam int unsigned MSB = qkc_pkg::TILE_BITS - 1;

	logic [qkc_pkg::TILE_BITS-1:0] col_q, col_n;
	logic [qkc_pkg::TILE_BITS-1:0] row_q, row_n;
	logic [qkc_pkg::ZOOM_W-1:0]    len_q, len_n;
	logic                          err_q, err_n;
	logic                          good_char;
	logic [1:0]                    val;

	assign good_char = (key_char >= qkc_pkg::CHAR_ZERO) && (key_char <= qkc_pkg::CHAR_THREE);
	assign val       = key_char[1:0];

	// next state after this character
	always_comb begin
		col_n = col_q;
		row_n = row_q;
		len_n = len_q;
		err_n = err_q;
		priority if (!good_char) begin
			err_n = 1'b1;
		end else if (len_q >= LIMIT) begin
			err_n = 1'b1;
		end else begin
			col_n = {col_q[MSB-1:0], val[0]};
			row_n = {row_q[MSB-1:0], val[1]};
			len_n = len_q + 1'b1;
		end
	end

	// decoder state, cleared after the marked character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			len_q <= '0;
			err_q <= 1'b0;
		end else if (char_valid) begin
			if (last_char) begin
				col_q <= '0;
				row_q <= '0;
				len_q <= '0;
				err_q <= 1'b0;
			end else begin
				col_q <= col_n;
				row_q <= row_n;
				len_q <= len_n;
				err_q <= err_n;
			end
		end
	end

	// result on the marked character; a failed key reports zeros
	always_comb begin
		res      = '0;
		res.last = 1'b1;
		res.ok   = !err_n;
		if (!err_n) begin
			res.x    = col_n;
			res.y    = row_n;
			res.zoom = len_n;
		end
	end

	assign res_valid = char_valid & last_char;

endmodule

`default_nettype wire

// File: sv/quadkey_codec.sv
// Quadkey codec top level: tile coordinate to key digits and back.
// Encode: the beat loads the digit counter and coordinate shifters, then each digit passes
// the output register, one digit per cycle unless m_tready stalls; no new beat while busy.
// Decode: one char per cycle unless stalled; the result shows the cycle after the last char.
// Reset: arst_n is asynchronous, active low; it clears the digit counter, the output
// valid and the decoder state.
`default_nettype none

module quadkey_codec #(
	parameter int unsigned MAX_ZOOM = 29
) (
	input  wire         clk,
	input  wire         arst_n,
	// slave side
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [71:0] s_tdata,  // tile_x[28:0], tile_y[57:29], zoom[62:58], key_char[70:63], 0
	input  wire         s_tuser,  // func
	input  wire         s_tlast,  // last_char
	// master side
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [71:0] m_tdata,  // digit_char[7:0], out_x[36:8], out_y[65:37], out_zoom[70:66], 0
	output logic        m_tuser,  // ok
	output logic        m_tlast   // last
);

	localparam int unsigned ZOOM_LIMIT =
		(MAX_ZOOM < qkc_pkg::TILE_BITS) ? MAX_ZOOM : qkc_pkg::TILE_BITS;

	logic                 out_free;
	logic                 accept;
	logic                 enc_start;
	logic                 dec_char;
	logic                 enc_busy;
	logic                 enc_valid;
	logic                 dec_valid;
	qkc_pkg::qkc_result_t enc_res;
	qkc_pkg::qkc_result_t dec_res;
	qkc_pkg::qkc_result_t res_q;
	logic                 m_tvalid_q;

	// input handshake: one item at a time, output register must have room
	assign out_free  = !m_tvalid_q || m_tready;
	assign s_tready  = !enc_busy && out_free;
	assign accept    = s_tvalid && s_tready;
	assign enc_start = accept && (s_tuser == qkc_pkg::FUNC_ENCODE);
	assign dec_char  = accept && (s_tuser == qkc_pkg::FUNC_DECODE);

	qkc_encoder #(
		.ZOOM_LIMIT(ZOOM_LIMIT)
	) u_encoder (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (enc_start),
		.advance  (out_free),
		.tile_x   (s_tdata[28:0]),
		.tile_y   (s_tdata[57:29]),
		.zoom     (s_tdata[62:58]),
		.busy     (enc_busy),
		.res_valid(enc_valid),
		.res      (enc_res)
	);

	qkc_decoder #(
		.ZOOM_LIMIT(ZOOM_LIMIT)
	) u_decoder (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_valid(dec_char),
		.key_char  (s_tdata[70:63]),
		.last_char (s_tlast),
		.res_valid (dec_valid),
		.res       (dec_res)
	);

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_free) begin
			m_tvalid_q <= enc_valid || dec_valid;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (out_free && (enc_valid || dec_valid)) begin
			res_q <= enc_valid ? enc_res : dec_res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, res_q.zoom, res_q.y, res_q.x, res_q.digit};
	assign m_tuser  = res_q.ok;
	assign m_tlast  = res_q.last;

`ifndef SYNTHESIS
	// encoder and decoder never offer a beat in the same cycle
	a_one_source: assert property (@(posedge clk) disable iff (!arst_n)
		!(enc_valid && dec_valid))
		else $error("encoder and decoder results collide");

	// no item is taken while digits are still being emitted
	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		enc_busy |-> !s_tready)
		else $error("input accepted during encode");

	// a failed decode carries all-zero fields
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata == '0 && m_tlast))
		else $error("failed decode with nonzero fields");

	// every emitted encode digit is an ASCII 0 to 3
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(enc_busy && out_free) |=> (m_tvalid && m_tdata[7:2] == 6'b001100))
		else $error("encoded digit out of range");
`endif

endmodule

`default_nettype wire
